>>> src/htd_pkg.sv
// Shared types and constants for the humidity/temperature frame decoder.
// No dependencies; htd_scale, the top level and the bench files refer to this package.
package htd_pkg;

	// Position of a byte within the six-byte measurement frame.
	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	// Configuration register indexes.
	localparam logic CFG_POLY  = 1'b0;
	localparam logic CFG_START = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [7:0] POLY_RESET  = 8'h31;
	localparam logic [7:0] START_RESET = 8'hFF;

	// Frame status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_CRC_ERR = 1'b1;

	// Fixed-point conversion constants (hundredths).
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUMI_SCALE  = 14'd10000;

endpackage

>>> src/htd_if.sv
// Channel interfaces of the frame decoder: received bytes in, decoded frames out.
// Depends on nothing; valid/ready handshake with source and sink modports.
interface htd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htd_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temp_centi_deg;
	logic [13:0]        humi_centi_pct;
	logic [15:0]        raw_temperature;
	logic [15:0]        raw_humidity;
	logic               frame_status;

	modport source (output valid, output temp_centi_deg, output humi_centi_pct,
		output raw_temperature, output raw_humidity, output frame_status, input ready);
	modport sink   (input valid, input temp_centi_deg, input humi_centi_pct,
		input raw_temperature, input raw_humidity, input frame_status, output ready);
endinterface

>>> src/htd_crc8.sv
// One-byte update of an MSB-first CRC-8 with a programmable polynomial.
// Purely combinational; no package dependencies.
module htd_crc8 (
	input  logic [7:0] crc_in,
	input  logic [7:0] data,
	input  logic [7:0] poly,
	output logic [7:0] crc_out
);

	// Eight shift-and-conditional-XOR steps, one per data bit.
	always_comb begin
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

>>> src/htd_scale.sv
// Conversion of the raw sensor words into hundredths of a degree and of a percent.
// Depends on htd_pkg for the scale and offset constants.
module htd_scale (
	input  logic [15:0]        raw_t,
	input  logic [15:0]        raw_h,
	output logic signed [14:0] temp_centi,
	output logic [13:0]        humi_centi
);

	logic [30:0] temp_prod;
	logic [29:0] humi_prod;
	logic [14:0] temp_floor;

	// Constant multiplies; the low 16 bits are dropped as a floor shift.
	assign temp_prod  = {16'd0, htd_pkg::TEMP_SCALE} * {15'd0, raw_t};
	assign humi_prod  = {16'd0, htd_pkg::HUMI_SCALE} * {14'd0, raw_h};
	assign temp_floor = temp_prod[30:16];

	// Offset applied in 15-bit two's complement; the range stays within it.
	assign temp_centi = signed'(temp_floor - htd_pkg::TEMP_OFFSET);
	assign humi_centi = humi_prod[29:16];

endmodule

>>> src/humidity_temperature_frame_decoder.sv
// Top level of the humidity/temperature frame decoder: input register, frame
// state, CRC check and result register. Depends on htd_pkg, htd_if, htd_crc8, htd_scale.
//
//   Channel  | Direction | Contents
//   ---------+-----------+-----------------------------------------------------
//   in_ch    | sink      | data_byte, frame_start (one frame byte)
//   out_ch   | source    | temp_centi_deg, humi_centi_pct, raw words, frame_status
//   cfg_*    | write     | index 0 polynomial, index 1 start value
//
// One byte is accepted per cycle unless a stalled out_ch holds a sixth byte. Bytes pass
// the input register; a frame's sixth byte reaches out_ch via the result register.
// The frame state and the output register are updated from the input register
// in a single pass; the CRC unit sits in that path, and both scale multipliers feed
// the result register from the frame state. Reset is asynchronous and clears the
// control state and configuration. A stall on out_ch holds only a sixth byte in the
// input register; other bytes keep flowing while a result waits to be taken.
module humidity_temperature_frame_decoder (
	input  logic      clk,
	input  logic      arst_n,
	htd_in_if.sink    in_ch,
	htd_out_if.source out_ch,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [7:0] cfg_wdata
);

	// Configuration registers.
	logic [7:0] poly_q;
	logic [7:0] start_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Frame state.
	htd_pkg::pos_t pos_q;
	logic [7:0]    crc_q;
	logic [7:0]    high_q;
	logic [7:0]    low_q;
	logic [15:0]   temp_word_q;
	logic          fail_q;

	// Result register.
	logic               out_valid_q;
	logic signed [14:0] temp_q;
	logic [13:0]        humi_q;
	logic [15:0]        raw_t_q;
	logic [15:0]        raw_h_q;
	logic               status_q;

	htd_pkg::pos_t      pos_eff;
	htd_pkg::pos_t      pos_next;
	logic [7:0]         crc_base;
	logic [7:0]         crc_fed;
	logic               step;
	logic               is_last;
	logic [15:0]        raw_h_cur;
	logic signed [14:0] temp_cur;
	logic [13:0]        humi_cur;

	// A frame_start byte, or a position that cannot occur, counts as the first byte.
	assign pos_eff  = (start_s1 || (pos_q > htd_pkg::POS_H_CRC)) ? htd_pkg::POS_T_HI : pos_q;
	assign pos_next = (pos_eff == htd_pkg::POS_H_CRC) ? htd_pkg::POS_T_HI
		: htd_pkg::pos_t'(pos_eff + 3'd1);
	assign is_last  = (pos_eff == htd_pkg::POS_H_CRC);

	// The input register moves on unless it holds a result the output cannot take.
	assign step        = valid_s1 && !(is_last && out_valid_q && !out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	// High bytes start a fresh CRC from the start value.
	assign crc_base = ((pos_eff == htd_pkg::POS_T_HI) || (pos_eff == htd_pkg::POS_H_HI))
		? start_q : crc_q;

	htd_crc8 u_crc (
		.crc_in  (crc_base),
		.data    (byte_s1),
		.poly    (poly_q),
		.crc_out (crc_fed)
	);

	assign raw_h_cur = {high_q, low_q};

	htd_scale u_scale (
		.raw_t      (temp_word_q),
		.raw_h      (raw_h_cur),
		.temp_centi (temp_cur),
		.humi_centi (humi_cur)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= htd_pkg::POLY_RESET;
			start_q <= htd_pkg::START_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				htd_pkg::CFG_POLY:  poly_q  <= cfg_wdata;
				htd_pkg::CFG_START: start_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1  <= in_ch.data_byte;
			start_s1 <= in_ch.frame_start;
		end
	end

	// Frame state update, one byte per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= htd_pkg::POS_T_HI;
			crc_q       <= htd_pkg::START_RESET;
			high_q      <= 8'd0;
			low_q       <= 8'd0;
			temp_word_q <= 16'd0;
			fail_q      <= 1'b0;
		end else if (step) begin
			pos_q <= pos_next;
			case (pos_eff)
				htd_pkg::POS_T_HI, htd_pkg::POS_H_HI: begin
					crc_q  <= crc_fed;
					high_q <= byte_s1;
				end
				htd_pkg::POS_T_LO: begin
					crc_q       <= crc_fed;
					temp_word_q <= {high_q, byte_s1};
				end
				htd_pkg::POS_T_CRC: begin
					fail_q <= (crc_q != byte_s1);
					crc_q  <= start_q;
				end
				htd_pkg::POS_H_LO: begin
					crc_q <= crc_fed;
					low_q <= byte_s1;
				end
				htd_pkg::POS_H_CRC: begin
					fail_q <= 1'b0;
					crc_q  <= start_q;
				end
				default: ;
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && is_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload, loaded on the last byte of a frame.
	always_ff @(posedge clk) begin
		if (step && is_last) begin
			temp_q   <= temp_cur;
			humi_q   <= humi_cur;
			raw_t_q  <= temp_word_q;
			raw_h_q  <= raw_h_cur;
			status_q <= (fail_q || (crc_q != byte_s1)) ? htd_pkg::STATUS_CRC_ERR
				: htd_pkg::STATUS_OK;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.temp_centi_deg  = temp_q;
	assign out_ch.humi_centi_pct  = humi_q;
	assign out_ch.raw_temperature = raw_t_q;
	assign out_ch.raw_humidity    = raw_h_q;
	assign out_ch.frame_status    = status_q;

endmodule

>>> src/htd_checker.sv
// Port-level checks for the frame decoder, bound to its top level.
// Depends only on the top level's ports; no package needed.
module htd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] temp_centi_deg,
	input logic [13:0]        humi_centi_pct
);

	// A pending result stays up until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	// A rising out_valid traces back to an input transaction, through the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

	// Input is only held off by a stalled result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// Converted values stay within the range that full-scale raw words can give.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humi_centi_pct <= 14'd9999) && (temp_centi_deg >= -15'sd4500)
			&& (temp_centi_deg <= 15'sd12999))
		else $error("converted value out of range");

endmodule

bind humidity_temperature_frame_decoder htd_checker u_htd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.temp_centi_deg (out_ch.temp_centi_deg),
	.humi_centi_pct (out_ch.humi_centi_pct)
);

>>> bench/htd_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker for the humidity/temperature frame decoder: predicts each decoded
// frame from the accepted bytes and register writes, and compares the results.
// Depends on htd_pkg and the channel interfaces in htd_if.
module htd_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	htd_in_if          in_mon,
	htd_out_if         out_mon,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         pending_count,
	output int         error_count
);

	// One decoded measurement frame as the block should deliver it.
	typedef struct packed {
		logic signed [14:0] temp_centi_deg;
		logic [13:0]        humi_centi_pct;
		logic [15:0]        raw_temperature;
		logic [15:0]        raw_humidity;
		logic               frame_status;
	} frame_result_t;

	frame_result_t expected_frames[$];

	// Mirror of the configuration registers.
	logic [7:0] crc_poly;
	logic [7:0] crc_start;

	// Mirror of the frame state.
	htd_pkg::pos_t frame_pos;
	logic [7:0]    crc_acc;
	logic [7:0]    hi_byte;
	logic [7:0]    lo_byte;
	logic [15:0]   temp_word;
	logic          crc_bad;

	// Feeds one byte, MSB first, into a CRC-8 register; no reflection, no final XOR.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] acc;
		acc = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (acc[7]) begin
				acc = {acc[6:0], 1'b0} ^ poly;
			end else begin
				acc = {acc[6:0], 1'b0};
			end
		end
		return acc;
	endfunction

	// Advances the frame state by one byte and queues a frame on the checksum byte
	// of the humidity word.
	task automatic decode_frame_byte(input logic [7:0] data, input logic start);
		htd_pkg::pos_t pos;
		int unsigned   rt;
		int unsigned   rh;
		int unsigned   t_full;
		int unsigned   h_full;
		frame_result_t frame;
		pos = start ? htd_pkg::POS_T_HI : frame_pos;
		case (pos)
			htd_pkg::POS_T_HI, htd_pkg::POS_H_HI: begin
				crc_acc = crc8_byte(crc_start, data, crc_poly);
				hi_byte = data;
			end
			htd_pkg::POS_T_LO: begin
				crc_acc = crc8_byte(crc_acc, data, crc_poly);
				temp_word = {hi_byte, data};
			end
			htd_pkg::POS_T_CRC: begin
				crc_bad = (crc_acc != data);
				crc_acc = crc_start;
			end
			htd_pkg::POS_H_LO: begin
				crc_acc = crc8_byte(crc_acc, data, crc_poly);
				lo_byte = data;
			end
			default: begin
				rt = 32'(temp_word);
				rh = 32'({hi_byte, lo_byte});
				t_full = ((32'(htd_pkg::TEMP_SCALE) * rt) >> 16) - 32'(htd_pkg::TEMP_OFFSET);
				h_full = (32'(htd_pkg::HUMI_SCALE) * rh) >> 16;
				frame.temp_centi_deg = t_full[14:0];
				frame.humi_centi_pct = h_full[13:0];
				frame.raw_temperature = temp_word;
				frame.raw_humidity = {hi_byte, lo_byte};
				frame.frame_status = (crc_bad || crc_acc != data) ? htd_pkg::STATUS_CRC_ERR
					: htd_pkg::STATUS_OK;
				expected_frames.push_back(frame);
				crc_bad = 1'b0;
				crc_acc = crc_start;
			end
		endcase
		frame_pos = (pos == htd_pkg::POS_H_CRC) ? htd_pkg::POS_T_HI
			: htd_pkg::pos_t'(pos + 3'd1);
	endtask

	// Reports one field that differs from the prediction.
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	initial error_count = 0;

	// Track register writes, accepted bytes and delivered frames.
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			crc_poly = htd_pkg::POLY_RESET;
			crc_start = htd_pkg::START_RESET;
			frame_pos = htd_pkg::POS_T_HI;
			crc_acc = htd_pkg::START_RESET;
			hi_byte = '0;
			lo_byte = '0;
			temp_word = '0;
			crc_bad = 1'b0;
			expected_frames.delete();
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == htd_pkg::CFG_POLY) begin
					crc_poly = cfg_wdata;
				end else begin
					crc_start = cfg_wdata;
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_frames.size() == 0) begin
					$error("decoded frame transaction with no frame expected");
					error_count++;
				end else begin
					want = expected_frames.pop_front();
					check_field("temp_centi_deg", int'(want.temp_centi_deg),
						int'(out_mon.temp_centi_deg));
					check_field("humi_centi_pct", int'(want.humi_centi_pct),
						int'(out_mon.humi_centi_pct));
					check_field("raw_temperature", int'(want.raw_temperature),
						int'(out_mon.raw_temperature));
					check_field("raw_humidity", int'(want.raw_humidity),
						int'(out_mon.raw_humidity));
					check_field("frame_status", int'(want.frame_status),
						int'(out_mon.frame_status));
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				decode_frame_byte(in_mon.data_byte, in_mon.frame_start);
			end
			pending_count <= expected_frames.size();
		end
	end

endmodule

>>> bench/humidity_temperature_frame_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench top for the humidity/temperature frame decoder: drives byte frames,
// register writes and output back-pressure, then gives the verdict.
// Depends on htd_pkg, htd_if, the decoder itself and htd_frame_checker.
module humidity_temperature_frame_decoder_tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int SEGMENTS     = 6;
	localparam int SEG_BYTES    = 117;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	htd_in_if  in_ch ();
	htd_out_if out_ch ();

	int pending_count;
	int error_count;

	// Idle percentages of the sender and the receiver, and the hold-off request.
	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_request = 1'b0;

	// Configuration the stimulus builds its checksums with.
	logic [7:0] crc_poly  = htd_pkg::POLY_RESET;
	logic [7:0] crc_start = htd_pkg::START_RESET;
	int         bytes_sent;
	logic       aligned;

	humidity_temperature_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	htd_frame_checker frame_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.pending_count (pending_count),
		.error_count   (error_count)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random back-pressure, with one long hold-off on request.
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Offers one byte after a random gap and waits for its transaction.
	task automatic send_byte(input logic [7:0] data, input logic start);
		int gap = 0;
		while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= data;
		in_ch.frame_start <= start;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	// Sends one six-byte frame; corrupt bit 0 spoils the temperature checksum,
	// bit 1 the humidity checksum.
	task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
		input logic [1:0] corrupt, input logic lead_start);
		logic [7:0] t_crc;
		logic [7:0] h_crc;
		t_crc = frame_chk.crc8_byte(frame_chk.crc8_byte(crc_start, t_word[15:8], crc_poly),
			t_word[7:0], crc_poly);
		h_crc = frame_chk.crc8_byte(frame_chk.crc8_byte(crc_start, h_word[15:8], crc_poly),
			h_word[7:0], crc_poly);
		if (corrupt[0]) t_crc ^= 8'($urandom_range(255, 1));
		if (corrupt[1]) h_crc ^= 8'($urandom_range(255, 1));
		send_byte(t_word[15:8], lead_start);
		send_byte(t_word[7:0], 1'b0);
		send_byte(t_crc, 1'b0);
		send_byte(h_word[15:8], 1'b0);
		send_byte(h_word[7:0], 1'b0);
		send_byte(h_crc, 1'b0);
		aligned = 1'b1;
	endtask

	// Random word, with the range ends picked now and then.
	function automatic logic [15:0] pick_word();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		end
		return 16'($urandom);
	endfunction

	// Stops offering bytes and waits until every frame is out and the pipe is empty.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers while the block is idle.
	task automatic write_config(input logic [7:0] poly, input logic [7:0] start);
		cfg_we <= 1'b1;
		cfg_index <= htd_pkg::CFG_POLY;
		cfg_wdata <= poly;
		@(posedge clk);
		cfg_index <= htd_pkg::CFG_START;
		cfg_wdata <= start;
		@(posedge clk);
		cfg_we <= 1'b0;
		crc_poly = poly;
		crc_start = start;
	endtask

	// Stimulus: directed frames under the reset settings, then random segments.
	initial begin
		logic [7:0] seg_poly[SEGMENTS];
		logic [7:0] seg_start[SEGMENTS];
		int         burst;
		seg_poly = '{8'h00, 8'hFF, 8'($urandom), htd_pkg::POLY_RESET, 8'hFF, 8'($urandom)};
		seg_start = '{8'h00, 8'hFF, 8'($urandom), htd_pkg::START_RESET, 8'h00, 8'($urandom)};
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.frame_start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= htd_pkg::CFG_POLY;
		cfg_wdata <= '0;
		send_idle_pct = 33;
		recv_idle_pct = 51;
		aligned = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Range ends of both words, wrap without a frame start, realignment in the
		// middle of a frame, and a checksum error in each word.
		send_frame(16'h0000, 16'hFFFF, 2'b00, 1'b1);
		send_frame(16'hFFFF, 16'h0000, 2'b00, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_frame(16'h6666, 16'h8000, 2'b01, 1'b1);
		send_frame(pick_word(), pick_word(), 2'b10, 1'b0);
		wait_drained();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			write_config(seg_poly[seg], seg_start[seg]);
			send_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 51 : 0;
			recv_idle_pct = (seg < 2) ? 51 : (seg < 4) ? 33 : 0;
			if (seg == 4) hold_request = 1'b1;
			bytes_sent = 0;
			while (bytes_sent < SEG_BYTES) begin
				if ($urandom_range(9) == 0) begin
					// Noise: stray bytes, sometimes with a frame start among them.
					burst = $urandom_range(7, 1);
					repeat (burst) send_byte(8'($urandom), $urandom_range(3) == 0);
					aligned = 1'b0;
				end else begin
					send_frame(pick_word(), pick_word(),
						($urandom_range(4) == 0) ? 2'($urandom_range(3, 1)) : 2'b00,
						aligned ? 1'($urandom_range(1)) : 1'b1);
				end
			end
			wait_drained();
		end

		if (pending_count != 0) $error("%0d decoded frames never arrived", pending_count);
		if (error_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
src/htd_pkg.sv
src/htd_if.sv
src/htd_crc8.sv
src/htd_scale.sv
src/humidity_temperature_frame_decoder.sv
src/htd_checker.sv
bench/htd_frame_checker.sv
bench/humidity_temperature_frame_decoder_tb.sv
